// ----- sv/czpd_pkg.sv -----
// Package for the camera zone preset director.
// Holds the sizes, configuration register indexes and the command and status
// structs shared by the controller, the datapath and the top level.
package czpd_pkg;

    localparam int ZONE_COUNT  = 16;
    localparam int PIXEL_BITS  = 12;
    localparam int COUNT_BITS  = 16;
    localparam int ZONE_BITS   = $clog2(ZONE_COUNT);
    localparam int PRESET_BITS = 5;
    localparam int CAM_BITS    = 8;
    localparam int OUT_PRESET_BITS = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_MIN   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NO_PERSON  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDE       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAMERA     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OVERLAP    = 3'd4;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_ZONE  = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NOT_HANDLED = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan1;
        logic scan2;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic hit;
        logic near;
        logic last;
        logic out_free;
    } t_status;

endpackage

// ----- sv/czpd_if.sv -----
// Handshake interfaces for the camera zone preset director channels.
// Depends on czpd_pkg for the field widths.
interface czpd_in_if;
    import czpd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [1:0]            person_count;
    logic [PIXEL_BITS-1:0] person_x;
    logic [3:0]            zone_index;
    logic [PIXEL_BITS-1:0] zone_left;
    logic [PIXEL_BITS-1:0] zone_right;
    logic                  zone_enable;

    modport source (output valid, action, person_count, person_x, zone_index,
                    zone_left, zone_right, zone_enable, input ready);
    modport sink (input valid, action, person_count, person_x, zone_index,
                  zone_left, zone_right, zone_enable, output ready);
endinterface

interface czpd_out_if;
    import czpd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       recall_valid;
    logic [CAM_BITS-1:0]        recall_camera;
    logic [OUT_PRESET_BITS-1:0] recall_preset;
    logic                       status;

    modport source (output valid, recall_valid, recall_camera, recall_preset, status,
                    input ready);
    modport sink (input valid, recall_valid, recall_camera, recall_preset, status,
                  output ready);
endinterface

interface czpd_cfg_if;
    import czpd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/czpd_ctrl.sv -----
// Sequencing controller of the camera zone preset director.
// Depends on czpd_pkg for the command and status structs.
module czpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  czpd_pkg::t_status i_status,
    output czpd_pkg::t_cmd    o_cmd
);
    import czpd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN1 = 2'd1;
    localparam logic [1:0] S_SCAN2 = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.need_scan ? S_SCAN1 : S_DONE;
                end
            end
            S_SCAN1: begin
                o_cmd.scan1 = 1'b1;
                if (i_status.hit && i_status.near) begin
                    n_state = S_SCAN2;
                end else if (i_status.hit || i_status.last) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN2: begin
                o_cmd.scan2 = 1'b1;
                if (i_status.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/czpd_dp.sv -----
// Datapath of the camera zone preset director: configuration registers,
// zone table, frame counters, scan index and output register.
// Depends on czpd_pkg; driven by czpd_ctrl through t_cmd.
module czpd_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  czpd_pkg::t_cmd                     i_cmd,
    output czpd_pkg::t_status                  o_status,
    input  logic                               i_cfg_we,
    input  logic [czpd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [czpd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_action,
    input  logic [1:0]                         i_person_count,
    input  logic [czpd_pkg::PIXEL_BITS-1:0]    i_person_x,
    input  logic [3:0]                         i_zone_index,
    input  logic [czpd_pkg::PIXEL_BITS-1:0]    i_zone_left,
    input  logic [czpd_pkg::PIXEL_BITS-1:0]    i_zone_right,
    input  logic                               i_zone_enable,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_recall_valid,
    output logic [czpd_pkg::CAM_BITS-1:0]      o_recall_camera,
    output logic [czpd_pkg::OUT_PRESET_BITS-1:0] o_recall_preset,
    output logic                               o_status_bit
);
    import czpd_pkg::*;

    localparam logic [COUNT_BITS-1:0]  CNT_MAX     = '1;
    localparam logic [PRESET_BITS-1:0] PRESET_NONE = '1;
    localparam logic [ZONE_BITS-1:0]   IDX_LAST    = ZONE_BITS'(ZONE_COUNT - 1);

    // Configuration registers.
    logic [COUNT_BITS-1:0]  r_hold_min;
    logic [COUNT_BITS-1:0]  r_no_person;
    logic [PRESET_BITS-1:0] r_wide;
    logic [CAM_BITS-1:0]    r_camera;
    logic [PIXEL_BITS-1:0]  r_overlap;

    // Tracking state.
    logic [PRESET_BITS-1:0] r_cur,   n_cur;
    logic [COUNT_BITS-1:0]  r_hold,  n_hold;
    logic [COUNT_BITS-1:0]  r_empty, n_empty;

    // Zone table.
    logic [PIXEL_BITS-1:0] r_left_mem  [ZONE_COUNT];
    logic [PIXEL_BITS-1:0] r_right_mem [ZONE_COUNT];
    logic [ZONE_COUNT-1:0] r_present;

    // Scan state.
    logic [PIXEL_BITS-1:0] r_x;
    logic [ZONE_BITS-1:0]  r_idx;
    logic [ZONE_BITS-1:0]  r_loc, n_loc;
    logic [PIXEL_BITS-1:0] r_edge;

    // Pending result and output register.
    logic                       r_res_rv,  n_res_rv;
    logic [OUT_PRESET_BITS-1:0] r_res_preset, n_res_preset;
    logic                       r_res_status, n_res_status;
    logic                       r_o_valid;
    logic                       r_o_rv;
    logic [CAM_BITS-1:0]        r_o_cam;
    logic [OUT_PRESET_BITS-1:0] r_o_preset;
    logic                       r_o_status;

    logic                  wide_on;
    logic [PIXEL_BITS-1:0] ent_l;
    logic [PIXEL_BITS-1:0] ent_r;
    logic                  ent_p;
    logic                  hit;
    logic                  near_l;
    logic                  near_r;
    logic                  cond2;
    logic                  do_resolve;
    logic [ZONE_BITS-1:0]  res_loc;
    logic                  need_scan;
    logic                  frame_accept;

    assign wide_on      = !r_wide[PRESET_BITS-1];
    assign frame_accept = i_cmd.accept && (i_action == ACT_FRAME);

    assign ent_l = r_left_mem[r_idx];
    assign ent_r = r_right_mem[r_idx];
    assign ent_p = r_present[r_idx];

    assign hit    = ent_p && (r_x >= ent_l) && (r_x < ent_r);
    assign near_l = {1'b0, r_x} < ({1'b0, ent_l} + {1'b0, r_overlap});
    // x >= r - ov, kept unsigned by moving the overlap to the left side.
    assign near_r = ({1'b0, r_x} + {1'b0, r_overlap}) >= {1'b0, ent_r};
    assign cond2  = ent_p && (r_edge > ent_l) && (r_edge < ent_r);

    assign n_loc      = cond2 ? r_idx : r_loc;
    assign res_loc    = i_cmd.scan1 ? r_idx : n_loc;
    assign do_resolve = (i_cmd.scan1 && hit && !near_l && !near_r)
                     || (i_cmd.scan2 && (r_idx == IDX_LAST));

    always_comb begin
        logic                   handled;
        logic [PRESET_BITS-1:0] cur_a;
        handled      = 1'b0;
        cur_a        = r_cur;
        need_scan    = 1'b0;
        n_cur        = r_cur;
        n_hold       = r_hold;
        n_empty      = r_empty;
        n_res_rv     = r_res_rv;
        n_res_preset = r_res_preset;
        n_res_status = r_res_status;
        if (i_cmd.accept) begin
            n_res_rv     = 1'b0;
            n_res_preset = '0;
            n_res_status = STATUS_OK;
        end
        if (frame_accept) begin
            if (wide_on && (r_cur == r_wide)) begin
                if ((r_hold < r_hold_min) && (r_hold != CNT_MAX)) begin
                    n_hold  = r_hold + 1'b1;
                    handled = 1'b1;
                end else begin
                    n_hold = '0;
                    cur_a  = PRESET_NONE;
                    n_cur  = PRESET_NONE;
                end
            end
            if (!handled) begin
                if ((i_person_count == 2'd0) && (r_empty < r_no_person)
                        && (r_empty != CNT_MAX)) begin
                    n_empty      = r_empty + 1'b1;
                    n_res_status = STATUS_NOT_HANDLED;
                end else begin
                    n_empty = '0;
                    if (i_person_count != 2'd1) begin
                        // Nobody for too long, or several people: wide shot.
                        if (wide_on) begin
                            n_cur        = r_wide;
                            n_hold       = COUNT_BITS'(1);
                            n_res_rv     = 1'b1;
                            n_res_preset = r_wide[OUT_PRESET_BITS-1:0];
                        end
                    end else begin
                        need_scan = 1'b1;
                        n_cur     = cur_a;
                    end
                end
            end
        end
        if (do_resolve) begin
            if (r_cur != PRESET_BITS'({1'b0, res_loc})) begin
                n_cur        = PRESET_BITS'({1'b0, res_loc});
                n_res_rv     = 1'b1;
                n_res_preset = OUT_PRESET_BITS'(res_loc);
            end
        end else if (i_cmd.scan1 && !hit && (r_idx == IDX_LAST)) begin
            n_res_status = STATUS_NOT_HANDLED;
        end
    end

    assign o_status.need_scan = need_scan;
    assign o_status.hit       = hit;
    assign o_status.near      = near_l || near_r;
    assign o_status.last      = (r_idx == IDX_LAST);
    assign o_status.out_free  = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_min  <= '0;
            r_no_person <= '0;
            r_wide      <= PRESET_NONE;
            r_camera    <= '0;
            r_overlap   <= '0;
            r_cur       <= PRESET_NONE;
            r_hold      <= '0;
            r_empty     <= '0;
            r_present   <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HOLD_MIN:  r_hold_min  <= i_cfg_data[COUNT_BITS-1:0];
                    CFG_NO_PERSON: r_no_person <= i_cfg_data[COUNT_BITS-1:0];
                    CFG_WIDE:      r_wide      <= i_cfg_data[PRESET_BITS-1:0];
                    CFG_CAMERA:    r_camera    <= i_cfg_data[CAM_BITS-1:0];
                    CFG_OVERLAP:   r_overlap   <= i_cfg_data[PIXEL_BITS-1:0];
                    default: ;
                endcase
            end
            r_cur   <= n_cur;
            r_hold  <= n_hold;
            r_empty <= n_empty;
            if (i_cmd.accept && (i_action == ACT_ZONE)
                    && (int'(i_zone_index) < ZONE_COUNT)) begin
                r_present[ZONE_BITS'(i_zone_index)] <= i_zone_enable;
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_action == ACT_ZONE)
                && (int'(i_zone_index) < ZONE_COUNT)) begin
            r_left_mem[ZONE_BITS'(i_zone_index)]  <= i_zone_left;
            r_right_mem[ZONE_BITS'(i_zone_index)] <= i_zone_right;
        end
        if (i_cmd.accept) begin
            r_x   <= i_person_x;
            r_idx <= '0;
        end else if (i_cmd.scan1 && hit) begin
            // A hit near an edge restarts the index for the neighbor search.
            r_idx  <= '0;
            r_loc  <= r_idx;
            r_edge <= near_l ? ent_l : ent_r;
        end else if (i_cmd.scan1 || i_cmd.scan2) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.scan2) begin
            r_loc <= n_loc;
        end
        r_res_rv     <= n_res_rv;
        r_res_preset <= n_res_preset;
        r_res_status <= n_res_status;
        if (i_cmd.load_out) begin
            r_o_rv     <= r_res_rv;
            r_o_cam    <= r_res_rv ? r_camera : '0;
            r_o_preset <= r_res_preset;
            r_o_status <= r_res_status;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_recall_valid  = r_o_rv;
    assign o_recall_camera = r_o_cam;
    assign o_recall_preset = r_o_preset;
    assign o_status_bit    = r_o_status;

endmodule

// ----- sv/camera_zone_preset_director.sv -----
// Camera zone preset director: takes one transaction per video frame (or per
// zone table write) and returns exactly one result transaction. Zone writes,
// and frames decided by the hold, empty-frame or several-people rules, pass
// from acceptance to the done state and, once the output register is free,
// into it. A single tracked person starts a scan of the 16-entry zone table,
// one entry per cycle through its single read port; a hit near a zone edge
// adds a second full pass for the neighbor search. A new input is taken as
// soon as the previous result sits in the output register.
// Configuration writes are always ready; index 0 hold_min_frames, 1
// no_person_limit, 2 wide_preset, 3 camera_number, 4 overlap_pixels.
// Depends on czpd_pkg, czpd_if, czpd_ctrl and czpd_dp.
module camera_zone_preset_director (
    input  logic        i_clk,
    input  logic        i_rst_n,
    czpd_in_if.sink     i_in,
    czpd_out_if.source  o_res,
    czpd_cfg_if.sink    i_cfg
);
    import czpd_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    czpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    czpd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_action        (i_in.action),
        .i_person_count  (i_in.person_count),
        .i_person_x      (i_in.person_x),
        .i_zone_index    (i_in.zone_index),
        .i_zone_left     (i_in.zone_left),
        .i_zone_right    (i_in.zone_right),
        .i_zone_enable   (i_in.zone_enable),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_recall_valid  (o_res.recall_valid),
        .o_recall_camera (o_res.recall_camera),
        .o_recall_preset (o_res.recall_preset),
        .o_status_bit    (o_res.status)
    );

endmodule
